### src/aagc_pkg.sv
// Shared constants, types and tables for the autoranging averager.
`default_nettype none
package aagc_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int GAIN_STEPS_DEF  = 4;

  // Fixed field widths
  localparam int SUM_BITS       = 32;
  localparam int AVG_OUT_BITS   = 16;
  localparam int CORR_BITS      = 30;
  localparam int GAIN_BITS      = 2;
  localparam int RELAY_BITS_W   = 3;
  localparam int WAIT_BITS      = 2;
  localparam int RECIP_BITS     = 32;
  localparam int OFFSET_BITS    = 16;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_MODE       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_THRESHOLD  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_THRESHOLD   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HYST_MARGIN     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP_LOW_PAIR  = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RECIP_HIGH_PAIR = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_TABLE    = 3'd7;

  // Gain mode codes
  localparam logic [2:0] GM_AUTO     = 3'd0;
  localparam logic [2:0] GM_FIXED_LO = 3'd1;
  localparam logic [2:0] GM_FIXED_HI = 3'd4;

  // Reset values
  localparam logic [15:0] WINDOW_LENGTH_RST = 16'd430;
  localparam logic [2:0]  GAIN_MODE_RST     = 3'd2;
  localparam logic [15:0] HIGH_THRESH_RST   = 16'd29491;
  localparam logic [15:0] LOW_THRESH_RST    = 16'd2621;
  localparam logic [15:0] HYST_MARGIN_RST   = 16'd1638;
  localparam logic [GAIN_BITS-1:0] GAIN_RST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef enum logic [WAIT_BITS-1:0] {
    WS_FREE  = 2'd0,
    WS_RAISE = 2'd1,
    WS_DROP  = 2'd2
  } wait_t;

  // Relay bits K3 K2 K1 for each gain step
  function automatic logic [RELAY_BITS_W-1:0] relay_for(input logic [GAIN_BITS-1:0] g);
    logic [RELAY_BITS_W-1:0] r;
    case (g)
      2'd0:    r = 3'b001;
      2'd1:    r = 3'b011;
      2'd2:    r = 3'b000;
      default: r = 3'b101;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### src/aagc_if.sv
// Valid/ready channel interfaces for samples and window results.
`default_nettype none
interface aagc_in_if #(
  parameter int SAMPLE_BITS = aagc_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface aagc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [aagc_pkg::AVG_OUT_BITS-1:0] average_raw;
  logic signed [aagc_pkg::CORR_BITS-1:0]    corrected_value;
  logic [aagc_pkg::GAIN_BITS-1:0]           gain_used;
  logic [aagc_pkg::GAIN_BITS-1:0]           next_gain;
  logic [aagc_pkg::RELAY_BITS_W-1:0]        relay_drive;
  logic [aagc_pkg::WAIT_BITS-1:0]           hysteresis_state;

  modport source (output valid, output average_raw, output corrected_value,
                  output gain_used, output next_gain, output relay_drive,
                  output hysteresis_state, input ready);
  modport sink   (input valid, input average_raw, input corrected_value,
                  input gain_used, input next_gain, input relay_drive,
                  input hysteresis_state, output ready);
endinterface
`default_nettype wire

### src/autorange_average_gain_control_top.sv
// Autoranging window averager with serial divide, serial gain correction and gain selector.
// Sequence: a sample inside a window is summed and yields no result; the closing sample runs
// through the divide, offset, multiply and output steps in that order to the result.
// Throughput: one sample per cycle within a window; input stalls at each window end during
// divide, offset, multiply and output, longer while the last result waits for the receiver.
// Reset (rst_n low, synchronous): register defaults, empty window, gain step 2, no result.
`default_nettype none
module autorange_average_gain_control_top #(
  parameter int SAMPLE_BITS = aagc_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = aagc_pkg::COUNT_BITS_DEF,
  parameter int GAIN_STEPS  = aagc_pkg::GAIN_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  aagc_in_if.sink                              in_ch,
  aagc_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [aagc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [aagc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import aagc_pkg::*;

  // Widths of the serial datapath
  localparam int DIFF_BITS  = SUM_BITS + 1;          // avg minus offset
  localparam int ACC_BITS   = RECIP_BITS + 3;        // running partial product
  localparam int PROD_BITS  = ACC_BITS + DIFF_BITS;  // full product
  localparam int CW         = PROD_BITS - 16;        // product after shift by 16
  localparam int CMP_W      = 25;                    // room for 16-bit length and count
  localparam int DIV_CNT_W  = $clog2(SUM_BITS);
  localparam int MUL_CNT_W  = $clog2(DIFF_BITS);
  localparam int THR_W      = 34;                    // signed compare of |avg| and limits

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic [GAIN_BITS-1:0]  GAIN_TOP    = GAIN_BITS'(GAIN_STEPS - 1);
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST    = DIV_CNT_W'(SUM_BITS - 1);
  localparam logic [MUL_CNT_W-1:0]  MUL_LAST    = MUL_CNT_W'(DIFF_BITS - 1);
  localparam logic signed [CW-1:0]  CORR_MAX    = CW'((64'd1 << (CORR_BITS - 1)) - 64'd1);
  localparam logic signed [CW-1:0]  CORR_MIN    = ~CORR_MAX;

  // Configuration registers
  logic [15:0]              window_length_r;
  logic [2:0]               gain_mode_r;
  logic [15:0]              high_threshold_r;
  logic [15:0]              low_threshold_r;
  logic [15:0]              hyst_margin_r;
  logic [CFG_DATA_BITS-1:0] recip_low_pair_r;
  logic [CFG_DATA_BITS-1:0] recip_high_pair_r;
  logic [CFG_DATA_BITS-1:0] offset_table_r;

  // Control state
  state_t                  state_r, state_nxt;
  logic [SUM_BITS-1:0]     sum_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [GAIN_BITS-1:0]    gain_r, gain_nxt;
  wait_t                   wait_r, wait_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Serial divider: quotient shifts in from the right while the dividend shifts out
  logic [SUM_BITS-1:0]     div_q_r;
  logic [COUNT_BITS-1:0]   div_rem_r;
  logic [COUNT_BITS-1:0]   div_den_r;
  logic                    div_neg_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;

  // Serial multiplier
  logic [DIFF_BITS-1:0]    mul_d_r;
  logic signed [ACC_BITS-1:0] mul_hi_r;
  logic [DIFF_BITS-1:0]    mul_lo_r;
  logic [MUL_CNT_W-1:0]    mul_cnt_r;
  logic [RECIP_BITS-1:0]   recip_r;
  logic [SUM_BITS-1:0]     abs_r;
  logic [SUM_BITS-1:0]     avg_r;

  // Output holding register
  logic signed [AVG_OUT_BITS-1:0] out_avg_r;
  logic signed [CORR_BITS-1:0]    out_corr_r;
  logic [GAIN_BITS-1:0]           out_used_r;
  logic [GAIN_BITS-1:0]           out_next_r;
  logic [RELAY_BITS_W-1:0]        out_relay_r;
  logic [WAIT_BITS-1:0]           out_wait_r;

  // ---------------------------------------------------------------------------
  // Sample intake: sum, count and window end detection
  // ---------------------------------------------------------------------------
  logic                          in_xfer;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [SUM_BITS-1:0]           sum_new;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [COUNT_BITS-1:0]         count_new;
  logic [CMP_W-1:0]              wl_ext;
  logic [CMP_W-1:0]              len_eff;
  logic                          window_end;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_sample   = in_ch.sample;

  // Sign-extend the sample into the wrapping 32-bit sum
  assign sum_new   = sum_r + SUM_BITS'(in_sample);
  assign sum_mag   = sum_new[SUM_BITS-1] ? (~sum_new + 1'b1) : sum_new;
  assign count_new = count_r + 1'b1;

  // A zero length acts as one; a length beyond the counter range clamps to its top
  always_comb begin
    wl_ext = CMP_W'(window_length_r);
    if (wl_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (wl_ext > CMP_W'(COUNT_LIMIT)) begin
      len_eff = CMP_W'(COUNT_LIMIT);
    end else begin
      len_eff = wl_ext;
    end
  end

  assign window_end = (CMP_W'(count_new) >= len_eff);

  // ---------------------------------------------------------------------------
  // Divide step: restoring, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [COUNT_BITS:0]   div_trial;
  logic                  div_fit;
  logic [COUNT_BITS:0]   div_sub;

  assign div_trial = {div_rem_r, div_q_r[SUM_BITS-1]};
  assign div_fit   = (div_trial >= {1'b0, div_den_r});
  assign div_sub   = div_trial - {1'b0, div_den_r};

  // ---------------------------------------------------------------------------
  // Offset step: average, offset and reciprocal for the gain step in use
  // ---------------------------------------------------------------------------
  logic [SUM_BITS-1:0]        avg_val;
  logic signed [OFFSET_BITS-1:0] offset_sel;
  logic [CFG_DATA_BITS-1:0]   recip_pair;
  logic [RECIP_BITS-1:0]      recip_sel;
  logic [DIFF_BITS-1:0]       diff_val;

  assign avg_val    = div_neg_r ? (~div_q_r + 1'b1) : div_q_r;
  assign offset_sel = offset_table_r[{gain_r, 4'b0000} +: OFFSET_BITS];
  assign recip_pair = gain_r[1] ? recip_high_pair_r : recip_low_pair_r;
  assign recip_sel  = gain_r[0] ? recip_pair[CFG_DATA_BITS-1:RECIP_BITS]
                                : recip_pair[RECIP_BITS-1:0];
  assign diff_val   = DIFF_BITS'($signed(avg_val)) - DIFF_BITS'(offset_sel);

  // ---------------------------------------------------------------------------
  // Multiply step: shift-add over the difference bits, the sign bit subtracts
  // ---------------------------------------------------------------------------
  logic signed [ACC_BITS-1:0] mul_addend;
  logic signed [ACC_BITS-1:0] mul_sum;

  assign mul_addend = mul_d_r[0] ? $signed({3'b000, recip_r}) : '0;
  assign mul_sum    = (mul_cnt_r == MUL_LAST) ? (mul_hi_r - mul_addend)
                                              : (mul_hi_r + mul_addend);

  // ---------------------------------------------------------------------------
  // Result: floor shift, saturation and gain selection
  // ---------------------------------------------------------------------------
  logic [PROD_BITS-1:0]       prod;
  logic signed [CW-1:0]       corr_wide;
  logic signed [CW-1:0]       corr_sat;
  logic signed [THR_W-1:0]    abs_s;
  logic signed [THR_W-1:0]    hi_s;
  logic signed [THR_W-1:0]    lo_s;
  logic signed [THR_W-1:0]    hi_release;
  logic signed [THR_W-1:0]    lo_release;
  logic [2:0]                 fixed_step;
  logic                       out_load;

  assign prod      = {mul_hi_r, mul_lo_r};
  // Arithmetic shift right by 16 rounds toward minus infinity
  assign corr_wide = $signed(prod[PROD_BITS-1:16]);

  always_comb begin
    if (corr_wide > CORR_MAX) begin
      corr_sat = CORR_MAX;
    end else if (corr_wide < CORR_MIN) begin
      corr_sat = CORR_MIN;
    end else begin
      corr_sat = corr_wide;
    end
  end

  assign abs_s      = $signed({2'b00, abs_r});
  assign hi_s       = $signed(THR_W'(high_threshold_r));
  assign lo_s       = $signed(THR_W'(low_threshold_r));
  assign hi_release = hi_s - $signed(THR_W'(hyst_margin_r));
  assign lo_release = lo_s + $signed(THR_W'(hyst_margin_r));
  assign fixed_step = gain_mode_r - GM_FIXED_LO;

  // Gain selector with hysteresis; evaluated in the output cycle only
  always_comb begin
    gain_nxt = gain_r;
    wait_nxt = wait_r;
    case (gain_mode_r) inside
      GM_AUTO: begin
        if (wait_r == WS_DROP) begin
          // After a drop, hold until the average falls clear of the high limit
          if (abs_s < hi_release) begin
            wait_nxt = WS_FREE;
          end
        end else if (wait_r == WS_RAISE) begin
          if (abs_s > lo_release) begin
            wait_nxt = WS_FREE;
          end
        end else begin
          if ((abs_s > hi_s) && (gain_r != '0)) begin
            gain_nxt = gain_r - 1'b1;
            wait_nxt = WS_DROP;
          end else if ((abs_s < lo_s) && (gain_r < GAIN_TOP)) begin
            gain_nxt = gain_r + 1'b1;
            wait_nxt = WS_RAISE;
          end
        end
      end
      [GM_FIXED_LO:GM_FIXED_HI]: begin
        // Fixed step, clamped to the top step; hysteresis state holds
        if (fixed_step > {1'b0, GAIN_TOP}) begin
          gain_nxt = GAIN_TOP;
        end else begin
          gain_nxt = fixed_step[GAIN_BITS-1:0];
        end
      end
      default: begin
        // Modes without meaning keep gain and hysteresis
      end
    endcase
  end

  // The result moves into the holding register once the previous one is gone
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && window_end) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_cnt_r == MUL_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      sum_r             <= '0;
      count_r           <= '0;
      gain_r            <= GAIN_RST;
      wait_r            <= WS_FREE;
      out_valid_r       <= 1'b0;
      window_length_r   <= WINDOW_LENGTH_RST;
      gain_mode_r       <= GAIN_MODE_RST;
      high_threshold_r  <= HIGH_THRESH_RST;
      low_threshold_r   <= LOW_THRESH_RST;
      hyst_margin_r     <= HYST_MARGIN_RST;
      recip_low_pair_r  <= '0;
      recip_high_pair_r <= '0;
      offset_table_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Accumulate; restart the window on its closing sample
      if (in_xfer) begin
        if (window_end) begin
          sum_r   <= '0;
          count_r <= '0;
        end else begin
          sum_r   <= sum_new;
          count_r <= count_new;
        end
      end

      if (out_load) begin
        gain_r <= gain_nxt;
        wait_r <= wait_nxt;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH:   window_length_r   <= cfg_data[15:0];
          CFG_GAIN_MODE:       gain_mode_r       <= cfg_data[2:0];
          CFG_HIGH_THRESHOLD:  high_threshold_r  <= cfg_data[15:0];
          CFG_LOW_THRESHOLD:   low_threshold_r   <= cfg_data[15:0];
          CFG_HYST_MARGIN:     hyst_margin_r     <= cfg_data[15:0];
          CFG_RECIP_LOW_PAIR:  recip_low_pair_r  <= cfg_data;
          CFG_RECIP_HIGH_PAIR: recip_high_pair_r <= cfg_data;
          CFG_OFFSET_TABLE:    offset_table_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        // Capture magnitude and sign of the closed window for the divider
        if (in_xfer && window_end) begin
          div_q_r   <= sum_mag;
          div_neg_r <= sum_new[SUM_BITS-1];
          div_den_r <= count_new;
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
      end
      ST_DIV: begin
        div_rem_r <= div_fit ? div_sub[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
        div_q_r   <= {div_q_r[SUM_BITS-2:0], div_fit};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      ST_DIFF: begin
        abs_r     <= div_q_r;
        avg_r     <= avg_val;
        recip_r   <= recip_sel;
        mul_d_r   <= diff_val;
        mul_hi_r  <= '0;
        mul_lo_r  <= '0;
        mul_cnt_r <= '0;
      end
      ST_MUL: begin
        // Advance one difference bit: add, then shift the pair right
        mul_hi_r  <= {mul_sum[ACC_BITS-1], mul_sum[ACC_BITS-1:1]};
        mul_lo_r  <= {mul_sum[0], mul_lo_r[DIFF_BITS-1:1]};
        mul_d_r   <= {1'b0, mul_d_r[DIFF_BITS-1:1]};
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_avg_r   <= avg_r[AVG_OUT_BITS-1:0];
          out_corr_r  <= corr_sat[CORR_BITS-1:0];
          out_used_r  <= gain_r;
          out_next_r  <= gain_nxt;
          out_relay_r <= relay_for(gain_nxt);
          out_wait_r  <= wait_nxt;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.average_raw      = out_avg_r;
  assign out_ch.corrected_value  = out_corr_r;
  assign out_ch.gain_used        = out_used_r;
  assign out_ch.next_gain        = out_next_r;
  assign out_ch.relay_drive      = out_relay_r;
  assign out_ch.hysteresis_state = out_wait_r;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the autoranging window averager and gain selector.
`default_nettype none
module tb;
  import aagc_pkg::*;

  // Wait after the last result before a register write, with slack for the block to go idle.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1000000;
  // Relay bits K3 K2 K1 per gain step, step 0 in the low three bits.
  localparam logic [11:0] RELAY_LUT = {3'b101, 3'b000, 3'b011, 3'b001};

  typedef struct packed {
    logic signed [AVG_OUT_BITS-1:0] avg;
    logic signed [CORR_BITS-1:0]    corr;
    logic [GAIN_BITS-1:0]           used;
    logic [GAIN_BITS-1:0]           nxt;
    logic [RELAY_BITS_W-1:0]        relay;
    logic [WAIT_BITS-1:0]           hyst;
  } window_result_t;

  // One line of the directed table: a register write or a sample, with an optional
  // hand-typed result for the sample.
  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic [15:0]               smp;
    logic                      typed;
    window_result_t            res;
  } plan_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  aagc_in_if  in_ch ();
  aagc_out_if out_ch ();

  autorange_average_gain_control_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block: register file and window state.
  logic [15:0] win_len;
  logic [2:0]  mode;
  logic [15:0] thr_hi, thr_lo, margin;
  logic [63:0] recip_lo_pair, recip_hi_pair, offsets;
  logic [31:0] acc_sum;
  logic [15:0] acc_count;
  logic [1:0]  cur_gain;
  wait_t       hold;

  window_result_t pending_windows[$];
  plan_row_t      directed_plan[$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 18;
  int recv_idle_pct  = 85;
  int level          = 0;

  // Fold one sample into the window; on a window end, fill in the result and return 1.
  function automatic bit fold_sample(input logic [15:0] s, output window_result_t r);
    logic [15:0] len;
    logic [1:0]  used;
    logic [63:0] pair;
    logic [31:0] recip;
    logic [15:0] ofs;
    longint avg, mag, diff, prod, corr, hi, lo, mg;
    r = '0;
    len = (win_len == 16'd0) ? 16'd1 : win_len;
    acc_sum   = acc_sum + {{16{s[15]}}, s};
    acc_count = acc_count + 16'd1;
    if (acc_count < len) return 1'b0;

    avg  = longint'($signed(acc_sum)) / longint'(acc_count);
    used = cur_gain;
    pair = used[1] ? recip_hi_pair : recip_lo_pair;
    recip = used[0] ? pair[63:32] : pair[31:0];
    ofs  = offsets[16*used +: 16];
    diff = avg - longint'($signed(ofs));
    prod = diff * longint'(recip);
    corr = prod >>> 16;
    if (corr > 64'sd536870911) corr = 64'sd536870911;
    if (corr < -64'sd536870912) corr = -64'sd536870912;

    mag = (avg < 0) ? -avg : avg;
    if (mode == GM_AUTO) begin
      hi = longint'(thr_hi);
      lo = longint'(thr_lo);
      mg = longint'(margin);
      if (hold == WS_DROP) begin
        if (mag < hi - mg) hold = WS_FREE;
      end else if (hold == WS_RAISE) begin
        if (mag > lo + mg) hold = WS_FREE;
      end else begin
        if (mag > hi && cur_gain > 2'd0) begin
          cur_gain = cur_gain - 2'd1;
          hold = WS_DROP;
        end else if (mag < lo && cur_gain < 2'd3) begin
          cur_gain = cur_gain + 2'd1;
          hold = WS_RAISE;
        end
      end
    end else if (mode <= GM_FIXED_HI) begin
      cur_gain = 2'(mode - GM_FIXED_LO);
    end

    r.avg   = avg[15:0];
    r.corr  = corr[29:0];
    r.used  = used;
    r.nxt   = cur_gain;
    r.relay = RELAY_LUT[3*cur_gain +: 3];
    r.hyst  = hold;
    acc_sum   = '0;
    acc_count = '0;
    return 1'b1;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [63:0] data);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.data   = data;
    return p;
  endfunction

  function automatic plan_row_t smp_row(input logic [15:0] s);
    plan_row_t p;
    p = '0;
    p.smp = s;
    return p;
  endfunction

  function automatic plan_row_t typed_row(input logic [15:0] s, input logic [15:0] avg,
                                          input logic [29:0] corr, input logic [1:0] used,
                                          input logic [1:0] nxt, input logic [2:0] relay,
                                          input logic [1:0] hyst);
    plan_row_t p;
    p = smp_row(s);
    p.typed = 1'b1;
    p.res   = {avg, corr, used, nxt, relay, hyst};
    return p;
  endfunction

  // Drop valid and hold off until every pending result is out and the block is quiet.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Drive one register write and mirror it in the shadow; leaves cfg_we high.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_WINDOW_LENGTH:   win_len       = data[15:0];
      CFG_GAIN_MODE:       mode          = data[2:0];
      CFG_HIGH_THRESHOLD:  thr_hi        = data[15:0];
      CFG_LOW_THRESHOLD:   thr_lo        = data[15:0];
      CFG_HYST_MARGIN:     margin        = data[15:0];
      CFG_RECIP_LOW_PAIR:  recip_lo_pair = data;
      CFG_RECIP_HIGH_PAIR: recip_hi_pair = data;
      default:             offsets       = data;
    endcase
    @(negedge clk);
  endtask

  // Offer one sample, idling first at random; predict once the transfer happens.
  task automatic send_sample(input logic [15:0] s, input logic typed = 1'b0,
                             input window_result_t want = '0);
    window_result_t r;
    bit got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    got = fold_sample(s, r);
    if (typed) pending_windows.push_back(want);
    else if (got) pending_windows.push_back(r);
    @(negedge clk);
  endtask

  // Samples cluster around a level that jumps between gain ranges, with some raw noise.
  function automatic logic [15:0] draw_sample();
    int v;
    if ($urandom_range(99) < 10) return 16'($urandom);
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       level = int'($urandom_range(2000));
        1:       level = int'($urandom_range(6000, 2000));
        2:       level = int'($urandom_range(32767, 20000));
        default: level = 32767;
      endcase
      if ($urandom_range(1) == 1) level = -level;
    end
    v = level + int'($urandom_range(400)) - 200;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'($urandom_range(32768));
      3:       return 16'($urandom_range(6000));
      4:       return 16'($urandom_range(32768, 20000));
      default: return 16'($urandom_range(3000, 1000));
    endcase
  endfunction

  // Draw a new register setting before each block of samples; window and mode are always written.
  task automatic reshuffle_settings();
    logic [63:0] d;
    wait_quiet();
    d = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       d[15:0] = 16'd0;
      1, 2:    d[15:0] = 16'($urandom_range(12, 5));
      3:       d[15:0] = 16'($urandom_range(40, 13));
      default: d[15:0] = 16'($urandom_range(4, 1));
    endcase
    write_register(CFG_WINDOW_LENGTH, d);
    d = {$urandom, $urandom};
    case ($urandom_range(9))
      0:             d[2:0] = 3'($urandom_range(7, 5));
      1, 2, 3:       d[2:0] = 3'($urandom_range(4, 1));
      default:       d[2:0] = GM_AUTO;
    endcase
    write_register(CFG_GAIN_MODE, d);
    if ($urandom_range(1) == 1) write_register(CFG_HIGH_THRESHOLD, {48'($urandom), pick_level()});
    if ($urandom_range(1) == 1) write_register(CFG_LOW_THRESHOLD, {48'($urandom), pick_level()});
    if ($urandom_range(1) == 1) write_register(CFG_HYST_MARGIN, {48'($urandom), pick_level()});
    for (int k = 0; k < 2; k++) begin
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(3))
          0:       d = {$urandom, $urandom};
          1:       d = {32'($urandom_range(32'h2_0000)), 32'($urandom_range(32'h2_0000))};
          2:       d = '1;
          default: d = '0;
        endcase
        write_register(k == 0 ? CFG_RECIP_LOW_PAIR : CFG_RECIP_HIGH_PAIR, d);
      end
    end
    if ($urandom_range(1) == 1) begin
      case ($urandom_range(2))
        0:       d = {$urandom, $urandom};
        1:       for (int k = 0; k < 4; k++) d[16*k +: 16] = 16'(int'($urandom_range(400)) - 200);
        default: d = '0;
      endcase
      write_register(CFG_OFFSET_TABLE, d);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall at random at the current rate, changing only at the falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic flag_field(input string name, input longint want, input longint seen);
    mismatch_count++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
  endtask

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    window_result_t seen, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.average_raw, out_ch.corrected_value, out_ch.gain_used,
              out_ch.next_gain, out_ch.relay_drive, out_ch.hysteresis_state};
      if (pending_windows.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got average_raw %0d",
                 $time, $signed(seen.avg));
      end else begin
        want = pending_windows.pop_front();
        if (seen.avg !== want.avg)
          flag_field("average_raw", $signed(want.avg), $signed(seen.avg));
        if (seen.corr !== want.corr)
          flag_field("corrected_value", $signed(want.corr), $signed(seen.corr));
        if (seen.used !== want.used) flag_field("gain_used", want.used, seen.used);
        if (seen.nxt !== want.nxt) flag_field("next_gain", want.nxt, seen.nxt);
        if (seen.relay !== want.relay) flag_field("relay_drive", want.relay, seen.relay);
        if (seen.hyst !== want.hyst) flag_field("hysteresis_state", want.hyst, seen.hyst);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    win_len       = WINDOW_LENGTH_RST;
    mode          = GAIN_MODE_RST;
    thr_hi        = HIGH_THRESH_RST;
    thr_lo        = LOW_THRESH_RST;
    margin        = HYST_MARGIN_RST;
    recip_lo_pair = '0;
    recip_hi_pair = '0;
    offsets       = '0;
    acc_sum       = '0;
    acc_count     = '0;
    cur_gain      = GAIN_RST;
    hold          = WS_FREE;

    // Directed table. Typed rows: reset state, full-scale samples, saturation.
    directed_plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 64'd1));
    directed_plan.push_back(typed_row(16'h7FFF, 16'h7FFF, 30'd0, 2'd2, 2'd1, 3'b011, WS_FREE));
    directed_plan.push_back(typed_row(16'h8000, 16'h8000, 30'd0, 2'd1, 2'd1, 3'b011, WS_FREE));
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'(GM_FIXED_HI)));
    directed_plan.push_back(typed_row(16'h0000, 16'h0000, 30'd0, 2'd1, 2'd3, 3'b101, WS_FREE));
    directed_plan.push_back(cfg_row(CFG_RECIP_LOW_PAIR, 64'hFFFF_FFFF_0001_0000));
    directed_plan.push_back(cfg_row(CFG_RECIP_HIGH_PAIR, 64'hFFFF_FFFF_0000_8000));
    directed_plan.push_back(cfg_row(CFG_OFFSET_TABLE, 64'hFFFF_8000_7FFF_0005));
    // Largest reciprocal on full-scale input clips at both ends of the corrected range.
    directed_plan.push_back(typed_row(16'h7FFF, 16'h7FFF, 30'h1FFF_FFFF, 2'd3, 2'd3, 3'b101,
                                      WS_FREE));
    directed_plan.push_back(typed_row(16'h8000, 16'h8000, 30'h2000_0000, 2'd3, 2'd3, 3'b101,
                                      WS_FREE));
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'(GM_FIXED_LO)));
    directed_plan.push_back(smp_row(16'hFFF9));
    directed_plan.push_back(smp_row(16'hFFF9));
    // Auto mode: raise, hold after raise, fixed mode keeping the wait state, release.
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'(GM_AUTO)));
    directed_plan.push_back(smp_row(16'd100));
    directed_plan.push_back(smp_row(16'd100));
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'd3));
    directed_plan.push_back(smp_row(16'd20000));
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'(GM_AUTO)));
    directed_plan.push_back(smp_row(16'd5000));
    // Drop, hold after drop, release on a small negative average.
    directed_plan.push_back(smp_row(16'd32000));
    directed_plan.push_back(smp_row(16'd32000));
    directed_plan.push_back(smp_row(16'hFF9C));
    // A gain mode with no meaning leaves gain and wait state alone.
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'd6));
    directed_plan.push_back(smp_row(16'd100));
    // Zero window length acts as one.
    directed_plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 64'd0));
    directed_plan.push_back(cfg_row(CFG_GAIN_MODE, 64'(GM_AUTO)));
    directed_plan.push_back(smp_row(16'd30000));
    directed_plan.push_back(smp_row(16'h7FFF));
    // High threshold below the margin: a drop never releases.
    directed_plan.push_back(cfg_row(CFG_HIGH_THRESHOLD, 64'd100));
    directed_plan.push_back(cfg_row(CFG_HYST_MARGIN, 64'd1000));
    directed_plan.push_back(smp_row(16'd0));
    directed_plan.push_back(cfg_row(CFG_HIGH_THRESHOLD, 64'(HIGH_THRESH_RST)));
    directed_plan.push_back(cfg_row(CFG_HYST_MARGIN, 64'(HYST_MARGIN_RST)));
    directed_plan.push_back(cfg_row(CFG_LOW_THRESHOLD, 64'(LOW_THRESH_RST)));
    // Window shortened below the samples already summed closes at the next sample.
    directed_plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 64'd10));
    directed_plan.push_back(smp_row(16'd1));
    directed_plan.push_back(smp_row(16'd2));
    directed_plan.push_back(smp_row(16'd3));
    directed_plan.push_back(cfg_row(CFG_WINDOW_LENGTH, 64'd2));
    directed_plan.push_back(smp_row(16'hFFF6));

    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        wait_quiet();
        write_register(directed_plan[i].idx, directed_plan[i].data);
      end else begin
        cfg_we <= 1'b0;
        send_sample(directed_plan[i].smp, directed_plan[i].typed, directed_plan[i].res);
      end
    end

    // Random part: receiver-heavy stalls, sender-heavy stalls, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        reshuffle_settings();
        repeat (40) send_sample(draw_sample());
      end
    end

    // Drain: wait for the last result, then let the block settle.
    in_ch.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_windows.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
